[rtl/tbu_pkg.sv]
// Package for the triangle tangent basis unit.
// Holds the field widths, the triangle record passed from front to back end
// and a small difference helper. No dependencies.
package tbu_pkg;

    localparam int COORD_W = 32;  // Q16.16 input field width
    localparam int DIFF_W  = 33;  // exact difference of two input fields
    localparam int PROD_W  = 66;  // exact product of two differences
    localparam int VEC_W   = 67;  // exact difference of two products
    localparam int OUT_W   = 16;  // Q2.14 result field width
    localparam int NORM_W  = 31;  // scaled magnitude width
    localparam int QUO_W   = 15;  // quotient bits of one component
    localparam int REM_W   = 48;  // divider remainder width
    localparam int ACC_W   = 64;  // sum of squares and root registers

    // Edges and UV deltas of one triangle, formed on its third corner.
    typedef struct packed {
        logic signed [DIFF_W-1:0] e1x;
        logic signed [DIFF_W-1:0] e1y;
        logic signed [DIFF_W-1:0] e1z;
        logic signed [DIFF_W-1:0] e2x;
        logic signed [DIFF_W-1:0] e2y;
        logic signed [DIFF_W-1:0] e2z;
        logic signed [DIFF_W-1:0] du1;
        logic signed [DIFF_W-1:0] dv1;
        logic signed [DIFF_W-1:0] du2;
        logic signed [DIFF_W-1:0] dv2;
    } tri_t;

    // Exact signed difference a - b of two Q16.16 values.
    function automatic logic signed [DIFF_W-1:0] sdiff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [DIFF_W-1:0] ax;
        logic signed [DIFF_W-1:0] bx;
        ax = DIFF_W'(a);
        bx = DIFF_W'(b);
        return ax - bx;
    endfunction

endpackage

[rtl/triangle_tangent_basis_unit.sv]
// Triangle tangent basis unit, top level.
// Triangle corners enter on the s_ channel, one transaction per corner, in
// index order: position and texture coordinate in signed Q16.16. The first
// two corners of a triangle are held; the third produces one transaction on
// the m_ channel with unit tangent and bitangent in signed Q2.14 and a
// degenerate flag (zero vectors when the UV determinant or a direction is
// zero). Corners one and two are taken every cycle. The third corner is
// taken as soon as the two-entry triangle queue has room.
// The back end forms all products on the shared 33x33 multiplier; unless the
// triangle is degenerate, it then takes each vector through scaling shifts,
// squares of its components, 32 square-root steps and three divisions.
// Results leave through an output register, so a stalled receiver holds the
// result while the queue keeps taking triangles. Reset clears the corner
// count, the queue and the output valid; no clearing pass is needed.
// Depends on tbu_pkg, tbu_front, tbu_fifo and tbu_back.
module triangle_tangent_basis_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [tbu_pkg::COORD_W-1:0] s_pos_x,
    input  logic signed [tbu_pkg::COORD_W-1:0] s_pos_y,
    input  logic signed [tbu_pkg::COORD_W-1:0] s_pos_z,
    input  logic signed [tbu_pkg::COORD_W-1:0] s_tex_u,
    input  logic signed [tbu_pkg::COORD_W-1:0] s_tex_v,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [tbu_pkg::OUT_W-1:0]   m_tangent_x,
    output logic signed [tbu_pkg::OUT_W-1:0]   m_tangent_y,
    output logic signed [tbu_pkg::OUT_W-1:0]   m_tangent_z,
    output logic signed [tbu_pkg::OUT_W-1:0]   m_bitangent_x,
    output logic signed [tbu_pkg::OUT_W-1:0]   m_bitangent_y,
    output logic signed [tbu_pkg::OUT_W-1:0]   m_bitangent_z,
    output logic                               m_degenerate
);

    logic          push_valid, push_ready, pop_valid, pop_ready;
    tbu_pkg::tri_t push_data, pop_data;

    // Corner collection and edge formation.
    tbu_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready,
        .s_pos_x, .s_pos_y, .s_pos_z, .s_tex_u, .s_tex_v,
        .push_valid, .push_ready, .push_data
    );

    // Triangle queue.
    tbu_fifo u_fifo (
        .aclk, .aresetn,
        .in_valid (push_valid), .in_ready (push_ready), .in_data (push_data),
        .out_valid(pop_valid),  .out_ready(pop_ready),  .out_data(pop_data)
    );

    // Basis computation and output register.
    tbu_back u_back (
        .aclk, .aresetn, .pop_valid, .pop_ready, .pop_data,
        .m_valid, .m_ready, .m_tangent_x, .m_tangent_y, .m_tangent_z,
        .m_bitangent_x, .m_bitangent_y, .m_bitangent_z, .m_degenerate
    );

endmodule

[rtl/tbu_front.sv]
// Front end of the triangle tangent basis unit: takes corners, holds the
// first two of each triangle and forms edges and UV deltas on the third.
// Depends on tbu_pkg.
module tbu_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [tbu_pkg::COORD_W-1:0]  s_pos_x,
    input  logic signed [tbu_pkg::COORD_W-1:0]  s_pos_y,
    input  logic signed [tbu_pkg::COORD_W-1:0]  s_pos_z,
    input  logic signed [tbu_pkg::COORD_W-1:0]  s_tex_u,
    input  logic signed [tbu_pkg::COORD_W-1:0]  s_tex_v,
    output logic                                push_valid,
    input  logic                                push_ready,
    output tbu_pkg::tri_t                       push_data
);

    logic [1:0] cnt_reg;
    logic signed [tbu_pkg::COORD_W-1:0] p0x_reg, p0y_reg, p0z_reg, u0_reg, v0_reg;
    logic signed [tbu_pkg::COORD_W-1:0] p1x_reg, p1y_reg, p1z_reg, u1_reg, v1_reg;
    logic third;
    logic accept;

    // The third corner needs room in the queue; the first two never stall.
    assign third      = (cnt_reg == 2'd2);
    assign s_ready    = !third || push_ready;
    assign push_valid = s_valid && third;
    assign accept     = s_valid && s_ready;

    // Edges and deltas relative to corner 0, all exact.
    always_comb begin
        push_data.e1x = tbu_pkg::sdiff(p1x_reg, p0x_reg);
        push_data.e1y = tbu_pkg::sdiff(p1y_reg, p0y_reg);
        push_data.e1z = tbu_pkg::sdiff(p1z_reg, p0z_reg);
        push_data.e2x = tbu_pkg::sdiff(s_pos_x, p0x_reg);
        push_data.e2y = tbu_pkg::sdiff(s_pos_y, p0y_reg);
        push_data.e2z = tbu_pkg::sdiff(s_pos_z, p0z_reg);
        push_data.du1 = tbu_pkg::sdiff(u1_reg, u0_reg);
        push_data.dv1 = tbu_pkg::sdiff(v1_reg, v0_reg);
        push_data.du2 = tbu_pkg::sdiff(s_tex_u, u0_reg);
        push_data.dv2 = tbu_pkg::sdiff(s_tex_v, v0_reg);
    end

    // Corner counter and held corners.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (accept) begin
            cnt_reg <= third ? 2'd0 : cnt_reg + 2'd1;
        end
        if (accept && cnt_reg == 2'd0) begin
            p0x_reg <= s_pos_x;
            p0y_reg <= s_pos_y;
            p0z_reg <= s_pos_z;
            u0_reg  <= s_tex_u;
            v0_reg  <= s_tex_v;
        end
        if (accept && cnt_reg == 2'd1) begin
            p1x_reg <= s_pos_x;
            p1y_reg <= s_pos_y;
            p1z_reg <= s_pos_z;
            u1_reg  <= s_tex_u;
            v1_reg  <= s_tex_v;
        end
    end

endmodule

[rtl/tbu_fifo.sv]
// Two-entry queue of triangle records between front and back end.
// Depends on tbu_pkg.
module tbu_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  tbu_pkg::tri_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output tbu_pkg::tri_t out_data
);

    tbu_pkg::tri_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= in_data;
    end

endmodule

[rtl/tbu_back.sv]
// Back end of the triangle tangent basis unit: forms determinant, tangent
// and bitangent with one shared multiplier, then normalizes each vector with
// a shift scaler, a bit-serial square root and a restoring divider.
// Depends on tbu_pkg.
module tbu_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               pop_valid,
    output logic                               pop_ready,
    input  tbu_pkg::tri_t                      pop_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [tbu_pkg::OUT_W-1:0]   m_tangent_x,
    output logic signed [tbu_pkg::OUT_W-1:0]   m_tangent_y,
    output logic signed [tbu_pkg::OUT_W-1:0]   m_tangent_z,
    output logic signed [tbu_pkg::OUT_W-1:0]   m_bitangent_x,
    output logic signed [tbu_pkg::OUT_W-1:0]   m_bitangent_y,
    output logic signed [tbu_pkg::OUT_W-1:0]   m_bitangent_z,
    output logic                               m_degenerate
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_CHECK, ST_LOAD, ST_SCALE,
        ST_SQUARE, ST_SQRT, ST_DIVINIT, ST_DIV, ST_EMIT
    } state_t;

    state_t state_reg;
    tbu_pkg::tri_t item_reg;
    logic [3:0] cnt_reg;
    logic signed [tbu_pkg::PROD_W-1:0] prod_reg;
    logic signed [tbu_pkg::VEC_W-1:0]  acc_reg;
    logic signed [tbu_pkg::VEC_W-1:0]  res_reg [7];
    logic [tbu_pkg::VEC_W-1:0]         mag_reg [3];
    logic [2:0]                        neg_reg;
    logic                              vsel_reg;
    logic [1:0]                        comp_reg;
    logic [tbu_pkg::ACC_W-1:0]         sq_reg;
    logic [tbu_pkg::ACC_W-1:0]         sum_reg;
    logic [tbu_pkg::ACC_W-1:0]         root_reg;
    logic [tbu_pkg::ACC_W-1:0]         bit_reg;
    logic [tbu_pkg::REM_W-1:0]         rem_reg;
    logic [tbu_pkg::QUO_W-1:0]         quo_reg;
    logic [3:0]                        k_reg;
    logic signed [tbu_pkg::OUT_W-1:0]  vout_reg [6];
    logic                              degen_reg;
    logic                              m_valid_reg;
    logic signed [tbu_pkg::OUT_W-1:0]  tx_reg, ty_reg, tz_reg, bx_reg, by_reg, bz_reg;
    logic                              mdeg_reg;

    logic signed [tbu_pkg::DIFF_W-1:0] opa;
    logic signed [tbu_pkg::DIFF_W-1:0] opb;
    logic [2:0]                        res_idx;
    logic [tbu_pkg::VEC_W-1:0]         or_mag;
    logic [tbu_pkg::NORM_W-1:0]        n_sel;
    logic [tbu_pkg::ACC_W-1:0]         trial_root;
    logic [tbu_pkg::REM_W-1:0]         trial_div;
    logic [tbu_pkg::QUO_W-1:0]         quo_fin;
    logic [tbu_pkg::OUT_W-1:0]         quo_ext;
    logic [tbu_pkg::OUT_W-1:0]         signed_q;
    logic signed [tbu_pkg::VEC_W-1:0]  vec_src [3];
    logic                              zero_t;
    logic                              zero_b;
    logic                              det_neg;
    logic [2:0]                        vout_idx;

    function automatic logic [tbu_pkg::REM_W-1:0] REM_W_EXT(input logic [31:0] r);
        return tbu_pkg::REM_W'(r);
    endfunction

    assign pop_ready     = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_tangent_x   = tx_reg;
    assign m_tangent_y   = ty_reg;
    assign m_tangent_z   = tz_reg;
    assign m_bitangent_x = bx_reg;
    assign m_bitangent_y = by_reg;
    assign m_bitangent_z = bz_reg;
    assign m_degenerate  = mdeg_reg;

    // Multiplier operand selection: two products per cross term.
    always_comb begin
        case (cnt_reg)
            4'd0:    begin opa = item_reg.du1; opb = item_reg.dv2; end
            4'd1:    begin opa = item_reg.du2; opb = item_reg.dv1; end
            4'd2:    begin opa = item_reg.dv2; opb = item_reg.e1x; end
            4'd3:    begin opa = item_reg.dv1; opb = item_reg.e2x; end
            4'd4:    begin opa = item_reg.dv2; opb = item_reg.e1y; end
            4'd5:    begin opa = item_reg.dv1; opb = item_reg.e2y; end
            4'd6:    begin opa = item_reg.dv2; opb = item_reg.e1z; end
            4'd7:    begin opa = item_reg.dv1; opb = item_reg.e2z; end
            4'd8:    begin opa = item_reg.du1; opb = item_reg.e2x; end
            4'd9:    begin opa = item_reg.du2; opb = item_reg.e1x; end
            4'd10:   begin opa = item_reg.du1; opb = item_reg.e2y; end
            4'd11:   begin opa = item_reg.du2; opb = item_reg.e1y; end
            4'd12:   begin opa = item_reg.du1; opb = item_reg.e2z; end
            4'd13:   begin opa = item_reg.du2; opb = item_reg.e1z; end
            default: begin opa = item_reg.du1; opb = item_reg.dv2; end
        endcase
    end

    // Helpers for the normalization steps.
    always_comb begin
        res_idx    = 3'((cnt_reg - 4'd1) >> 1);
        or_mag     = mag_reg[0] | mag_reg[1] | mag_reg[2];
        n_sel      = mag_reg[comp_reg][tbu_pkg::NORM_W-1:0];
        trial_root = root_reg + bit_reg;
        trial_div  = REM_W_EXT(root_reg[31:0]) << (k_reg + 4'd1);
        quo_fin    = (rem_reg >= trial_div) ? (quo_reg | (tbu_pkg::QUO_W'(1) << k_reg))
                                            : quo_reg;
        quo_ext    = tbu_pkg::OUT_W'(quo_fin);
        signed_q   = neg_reg[comp_reg] ? (~quo_ext + 1'b1) : quo_ext;
        vout_idx   = vsel_reg ? 3'(comp_reg) + 3'd3 : 3'(comp_reg);
        det_neg    = res_reg[0][tbu_pkg::VEC_W-1];
        zero_t     = (res_reg[1] == '0) && (res_reg[2] == '0) && (res_reg[3] == '0);
        zero_b     = (res_reg[4] == '0) && (res_reg[5] == '0) && (res_reg[6] == '0);
        for (int i = 0; i < 3; i++) begin
            vec_src[i] = vsel_reg ? res_reg[4 + i] : res_reg[1 + i];
        end
    end

    // Sequencer with its datapath and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // The emit state either reloads or holds the output register itself.
            if (state_reg != ST_EMIT && m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop_valid) begin
                        item_reg  <= pop_data;
                        cnt_reg   <= 4'd0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (cnt_reg != 4'd14) prod_reg <= opa * opb;
                    if (cnt_reg != 4'd0) begin
                        if (!cnt_reg[0]) begin
                            res_reg[res_idx] <= acc_reg - tbu_pkg::VEC_W'(prod_reg);
                        end else begin
                            acc_reg <= tbu_pkg::VEC_W'(prod_reg);
                        end
                    end
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd14) state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    vsel_reg <= 1'b0;
                    if (res_reg[0] == '0 || zero_t || zero_b) begin
                        degen_reg <= 1'b1;
                        for (int i = 0; i < 6; i++) vout_reg[i] <= '0;
                        state_reg <= ST_EMIT;
                    end else begin
                        degen_reg <= 1'b0;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= vec_src[i][tbu_pkg::VEC_W-1] ? -vec_src[i]
                                                                    : vec_src[i];
                        neg_reg[i] <= vec_src[i][tbu_pkg::VEC_W-1] ^ det_neg;
                    end
                    state_reg <= ST_SCALE;
                end
                ST_SCALE: begin
                    // Bring the largest magnitude into [2^30, 2^31), one bit a cycle.
                    if (or_mag[tbu_pkg::VEC_W-1:tbu_pkg::NORM_W] != '0) begin
                        for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                    end else if (!or_mag[tbu_pkg::NORM_W-1]) begin
                        for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                    end else begin
                        comp_reg  <= 2'd0;
                        sum_reg   <= '0;
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE: begin
                    if (comp_reg != 2'd0) sum_reg <= sum_reg + sq_reg;
                    if (comp_reg == 2'd3) begin
                        root_reg  <= '0;
                        bit_reg   <= tbu_pkg::ACC_W'(1) << (tbu_pkg::ACC_W - 2);
                        state_reg <= ST_SQRT;
                    end else begin
                        sq_reg   <= tbu_pkg::ACC_W'(n_sel) * tbu_pkg::ACC_W'(n_sel);
                        comp_reg <= comp_reg + 2'd1;
                    end
                end
                ST_SQRT: begin
                    // One result bit per cycle.
                    if (sum_reg >= trial_root) begin
                        sum_reg  <= sum_reg - trial_root;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg == tbu_pkg::ACC_W'(1)) begin
                        comp_reg  <= 2'd0;
                        state_reg <= ST_DIVINIT;
                    end
                end
                ST_DIVINIT: begin
                    rem_reg   <= (tbu_pkg::REM_W'(n_sel) << 15) + REM_W_EXT(root_reg[31:0]);
                    quo_reg   <= '0;
                    k_reg     <= 4'(tbu_pkg::QUO_W - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    // Restoring division by twice the root, one quotient bit a cycle.
                    if (rem_reg >= trial_div) rem_reg <= rem_reg - trial_div;
                    quo_reg <= quo_fin;
                    k_reg   <= k_reg - 4'd1;
                    if (k_reg == 4'd0) begin
                        vout_reg[vout_idx] <= signed_q;
                        if (comp_reg != 2'd2) begin
                            comp_reg  <= comp_reg + 2'd1;
                            state_reg <= ST_DIVINIT;
                        end else if (!vsel_reg) begin
                            vsel_reg  <= 1'b1;
                            state_reg <= ST_LOAD;
                        end else begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        tx_reg      <= vout_reg[0];
                        ty_reg      <= vout_reg[1];
                        tz_reg      <= vout_reg[2];
                        bx_reg      <= vout_reg[3];
                        by_reg      <= vout_reg[4];
                        bz_reg      <= vout_reg[5];
                        mdeg_reg    <= degen_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[rtl/tbu_checker.sv]
// Port checker for the triangle tangent basis unit, with its bind statement.
// Depends on triangle_tangent_basis_unit.
module tbu_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic signed [15:0] m_tangent_x,
    input logic signed [15:0] m_tangent_y,
    input logic signed [15:0] m_tangent_z,
    input logic signed [15:0] m_bitangent_x,
    input logic signed [15:0] m_bitangent_y,
    input logic signed [15:0] m_bitangent_z,
    input logic              m_degenerate
);

    // A stalled result stays valid and keeps its tangent x and degenerate flag.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tangent_x) && $stable(m_degenerate))
        else $error("result changed while stalled");

    // A degenerate triangle carries zero vectors.
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_tangent_x == 0 && m_tangent_y == 0 &&
        m_tangent_z == 0 && m_bitangent_x == 0 && m_bitangent_y == 0 &&
        m_bitangent_z == 0)
        else $error("degenerate result with nonzero vector");

    // A proper basis has a nonzero tangent and bitangent.
    a_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_degenerate |-> (m_tangent_x != 0 || m_tangent_y != 0 ||
        m_tangent_z != 0) && (m_bitangent_x != 0 || m_bitangent_y != 0 ||
        m_bitangent_z != 0))
        else $error("zero vector without degenerate flag");

    // The x components of tangent and bitangent never exceed one in magnitude in Q2.14.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_tangent_x <= 16384 && m_tangent_x >= -16384 &&
        m_bitangent_x <= 16384 && m_bitangent_x >= -16384)
        else $error("component outside unit range");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind triangle_tangent_basis_unit tbu_checker u_tbu_checker (
    .aclk, .aresetn, .m_valid, .m_ready,
    .m_tangent_x, .m_tangent_y, .m_tangent_z,
    .m_bitangent_x, .m_bitangent_y, .m_bitangent_z, .m_degenerate
);

[tb/sv/tb_triangle_tangent_basis_unit.sv]
// Self-checking testbench for triangle_tangent_basis_unit: directed and random triangles,
// with random idle gaps and stalls on both sides, checked against an exact fixed-point predictor.
// Depends on tbu_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb_triangle_tangent_basis_unit;

    localparam int  CLK_HALF    = 6;
    localparam int  CORNER_GOAL = 1250;
    localparam int  DRAIN_WAIT  = 600;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef logic signed [tbu_pkg::VEC_W-1:0] vec_t;

    // One expected result transaction.
    typedef struct {
        logic signed [tbu_pkg::OUT_W-1:0] tx, ty, tz;
        logic signed [tbu_pkg::OUT_W-1:0] bx, by, bz;
        logic                             degen;
    } basis_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic signed [tbu_pkg::COORD_W-1:0] s_pos_x, s_pos_y, s_pos_z, s_tex_u, s_tex_v;
    logic                               m_valid;
    logic                               m_ready;
    logic signed [tbu_pkg::OUT_W-1:0]   m_tangent_x, m_tangent_y, m_tangent_z;
    logic signed [tbu_pkg::OUT_W-1:0]   m_bitangent_x, m_bitangent_y, m_bitangent_z;
    logic                               m_degenerate;

    basis_t basis_queue[$];
    int     mismatches;
    int     corners_sent;
    int     triangles_checked;
    int     degenerate_seen;
    longint cycle_count;

    // Predictor state: corners held for the current triangle.
    int                                 held_corners;
    logic signed [tbu_pkg::COORD_W-1:0] held_pos[6];
    logic signed [tbu_pkg::COORD_W-1:0] held_tex[4];

    triangle_tangent_basis_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_pos_z       (s_pos_z),
        .s_tex_u       (s_tex_u),
        .s_tex_v       (s_tex_v),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tangent_x   (m_tangent_x),
        .m_tangent_y   (m_tangent_y),
        .m_tangent_z   (m_tangent_z),
        .m_bitangent_x (m_bitangent_x),
        .m_bitangent_y (m_bitangent_y),
        .m_bitangent_z (m_bitangent_z),
        .m_degenerate  (m_degenerate)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Exact a*b - c*d on sign-extended differences.
    function automatic vec_t cross_diff(input logic signed [tbu_pkg::DIFF_W-1:0] a,
                                        input logic signed [tbu_pkg::DIFF_W-1:0] b,
                                        input logic signed [tbu_pkg::DIFF_W-1:0] c,
                                        input logic signed [tbu_pkg::DIFF_W-1:0] d);
        vec_t wa, wb, wc, wd;
        wa = a;
        wb = b;
        wc = c;
        wd = d;
        return wa * wb - wc * wd;
    endfunction

    // Scale a nonzero vector to unit length in Q2.14, inverting the sign when flip is set.
    function automatic void unit_vector(input vec_t v0, input vec_t v1, input vec_t v2,
                                        input logic flip,
                                        output logic signed [tbu_pkg::OUT_W-1:0] o0,
                                        output logic signed [tbu_pkg::OUT_W-1:0] o1,
                                        output logic signed [tbu_pkg::OUT_W-1:0] o2);
        vec_t                      v[3];
        logic [tbu_pkg::VEC_W-1:0] mag[3];
        logic [63:0]               n[3];
        logic [63:0]               sum, root, bitv, q;
        logic [tbu_pkg::OUT_W-1:0] o[3];
        int                        maxlen;
        v[0] = v0;
        v[1] = v1;
        v[2] = v2;
        maxlen = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = v[i][tbu_pkg::VEC_W-1] ? -v[i] : v[i];
            for (int j = 0; j < tbu_pkg::VEC_W; j++)
                if (mag[i][j] && j + 1 > maxlen) maxlen = j + 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            if (maxlen > 31) n[i] = 64'(mag[i] >> (maxlen - 31));
            else n[i] = 64'(mag[i] << (31 - maxlen));
            sum += n[i] * n[i];
        end
        // Integer square root, bit by bit.
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > sum) bitv >>= 2;
        while (bitv != 0) begin
            if (sum >= root + bitv) begin
                sum  -= root + bitv;
                root  = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        for (int i = 0; i < 3; i++) begin
            q = ((n[i] << 15) + root) / (2 * root);
            o[i] = (v[i][tbu_pkg::VEC_W-1] != flip) ? -q[tbu_pkg::OUT_W-1:0]
                                                     : q[tbu_pkg::OUT_W-1:0];
        end
        o0 = o[0];
        o1 = o[1];
        o2 = o[2];
    endfunction

    // Advance the predictor by one accepted corner; queue a result on the third one.
    function automatic void predict_corner(input logic signed [tbu_pkg::COORD_W-1:0] px,
                                           input logic signed [tbu_pkg::COORD_W-1:0] py,
                                           input logic signed [tbu_pkg::COORD_W-1:0] pz,
                                           input logic signed [tbu_pkg::COORD_W-1:0] u,
                                           input logic signed [tbu_pkg::COORD_W-1:0] w);
        logic signed [tbu_pkg::DIFF_W-1:0]  e1[3], e2[3];
        logic signed [tbu_pkg::DIFF_W-1:0]  du1, dv1, du2, dv2;
        logic signed [tbu_pkg::COORD_W-1:0] p2[3];
        vec_t   det, t[3], b[3];
        basis_t res;
        if (held_corners < 2) begin
            held_pos[held_corners*3]     = px;
            held_pos[held_corners*3 + 1] = py;
            held_pos[held_corners*3 + 2] = pz;
            held_tex[held_corners*2]     = u;
            held_tex[held_corners*2 + 1] = w;
            held_corners++;
            return;
        end
        held_corners = 0;
        p2[0] = px;
        p2[1] = py;
        p2[2] = pz;
        for (int i = 0; i < 3; i++) begin
            e1[i] = tbu_pkg::sdiff(held_pos[3 + i], held_pos[i]);
            e2[i] = tbu_pkg::sdiff(p2[i], held_pos[i]);
        end
        du1 = tbu_pkg::sdiff(held_tex[2], held_tex[0]);
        dv1 = tbu_pkg::sdiff(held_tex[3], held_tex[1]);
        du2 = tbu_pkg::sdiff(u, held_tex[0]);
        dv2 = tbu_pkg::sdiff(w, held_tex[1]);
        det = cross_diff(du1, dv2, du2, dv1);
        for (int i = 0; i < 3; i++) begin
            t[i] = cross_diff(dv2, e1[i], dv1, e2[i]);
            b[i] = cross_diff(du1, e2[i], du2, e1[i]);
        end
        res = '{default: '0};
        if (det == 0 || (t[0] == 0 && t[1] == 0 && t[2] == 0)
                     || (b[0] == 0 && b[1] == 0 && b[2] == 0)) begin
            res.degen = 1'b1;
        end else begin
            unit_vector(t[0], t[1], t[2], det[tbu_pkg::VEC_W-1], res.tx, res.ty, res.tz);
            unit_vector(b[0], b[1], b[2], det[tbu_pkg::VEC_W-1], res.bx, res.by, res.bz);
        end
        basis_queue.insert(basis_queue.size(), res);
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at cycle %0d: got %0h, expected %0h",
                 what, cycle_count, got, want);
        mismatches++;
    endtask

    // Random gap length: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Cycle counter and timeout.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[triangle_tangent_basis_unit] ERROR");
            $finish;
        end
    end

    // Receiver back-pressure: random stalls of random length.
    int stall_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready    <= 1'b1;
            stall_left <= (m_ready && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        end
    end

    // Accepted corners feed the predictor; accepted results are checked in order.
    always @(posedge aclk) begin
        basis_t want;
        if (aresetn && s_valid && s_ready)
            predict_corner(s_pos_x, s_pos_y, s_pos_z, s_tex_u, s_tex_v);
        if (aresetn && m_valid && m_ready) begin
            if (basis_queue.size() == 0) begin
                $display("unexpected result transaction at cycle %0d", cycle_count);
                mismatches++;
            end else begin
                want = basis_queue.pop_front();
                triangles_checked++;
                if (want.degen) degenerate_seen++;
                if (m_tangent_x !== want.tx) report_mismatch("tangent_x", m_tangent_x, want.tx);
                if (m_tangent_y !== want.ty) report_mismatch("tangent_y", m_tangent_y, want.ty);
                if (m_tangent_z !== want.tz) report_mismatch("tangent_z", m_tangent_z, want.tz);
                if (m_bitangent_x !== want.bx)
                    report_mismatch("bitangent_x", m_bitangent_x, want.bx);
                if (m_bitangent_y !== want.by)
                    report_mismatch("bitangent_y", m_bitangent_y, want.by);
                if (m_bitangent_z !== want.bz)
                    report_mismatch("bitangent_z", m_bitangent_z, want.bz);
                if (m_degenerate !== want.degen)
                    report_mismatch("degenerate", m_degenerate, want.degen);
            end
        end
    end

    // Sends one corner after a random gap, possibly none, and waits until the transaction is taken.
    task automatic send_corner(input logic [31:0] px, input logic [31:0] py,
                               input logic [31:0] pz, input logic [31:0] u,
                               input logic [31:0] w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pos_x <= px;
        s_pos_y <= py;
        s_pos_z <= pz;
        s_tex_u <= u;
        s_tex_v <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        corners_sent++;
    endtask

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV = 32'h8000_0000;

    // Simple triangles with both signs of determinant, a zero determinant and
    // coincident positions, then the extremes of the input range and one-LSB values.
    task automatic test_directed();
        send_corner(0, 0, 0, 0, 0);
        send_corner(ONE, 0, 0, ONE, 0);
        send_corner(0, ONE, 0, 0, ONE);
        send_corner(0, 0, 0, 0, 0);
        send_corner(ONE, 0, 0, 0, ONE);
        send_corner(0, ONE, ONE, ONE, 0);
        send_corner(ONE, 2 * ONE, 3 * ONE, ONE, ONE);
        send_corner(0, 0, ONE, ONE, ONE);
        send_corner(ONE, 0, 0, ONE, ONE);
        send_corner(ONE, ONE, ONE, 0, 0);
        send_corner(ONE, ONE, ONE, ONE, 0);
        send_corner(ONE, ONE, ONE, 0, ONE);
        send_corner(MINV, MINV, MINV, MAXV, MAXV);
        send_corner(MAXV, MINV, MAXV, MINV, MAXV);
        send_corner(MINV, MAXV, MAXV, MAXV, MINV);
        send_corner(MAXV, MAXV, MAXV, MINV, MINV);
        send_corner(MINV, MINV, MINV, MAXV, MINV);
        send_corner(32'hFFFF_FFFF, MAXV, MINV, MINV, MAXV);
        send_corner(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
        send_corner(1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1);
        send_corner(1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Coordinate of a given flavour: full range, small around zero, or near a limit.
    function automatic logic [31:0] rand_coord(input int flavour);
        case (flavour)
            0: return $urandom;
            1: return 32'($urandom_range(0, 8 * ONE)) - 4 * ONE;
            default: return $urandom_range(0, 1) ? MAXV - $urandom_range(0, 255)
                                                 : MINV + $urandom_range(0, 255);
        endcase
    endfunction

    // Random triangles, mostly well formed, some with degenerate UVs or positions.
    task automatic test_random();
        logic [31:0] c[3][5];
        int kind, flavour;
        while (corners_sent < CORNER_GOAL) begin
            kind    = $urandom_range(0, 99);
            flavour = $urandom_range(0, 9) < 5 ? 0 : ($urandom_range(0, 3) == 0 ? 2 : 1);
            for (int k = 0; k < 3; k++)
                for (int f = 0; f < 5; f++) c[k][f] = rand_coord(flavour);
            if (kind < 8) begin
                // Collinear texture coordinates give a zero determinant.
                c[2][3] = c[1][3];
                c[2][4] = c[1][4];
                c[1][3] = c[0][3];
                c[1][4] = c[0][4];
            end else if (kind < 14) begin
                for (int f = 0; f < 3; f++) begin
                    c[1][f] = c[0][f];
                    c[2][f] = c[0][f];
                end
            end else if (kind < 20) begin
                // Tiny UV deltas stress the normalisation shift.
                c[1][3] = c[0][3] + $urandom_range(0, 2);
                c[1][4] = c[0][4] + $urandom_range(0, 2);
                c[2][3] = c[0][3] - $urandom_range(0, 2);
                c[2][4] = c[0][4] + $urandom_range(0, 2);
            end
            for (int k = 0; k < 3; k++)
                send_corner(c[k][0], c[k][1], c[k][2], c[k][3], c[k][4]);
        end
    endtask

    // Main sequence: reset, tests, drain and verdict.
    initial begin
        int waited;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_pos_x      = '0;
        s_pos_y      = '0;
        s_pos_z      = '0;
        s_tex_u      = '0;
        s_tex_v      = '0;
        held_corners = 0;
        mismatches   = 0;
        corners_sent = 0;
        cycle_count  = 0;
        triangles_checked = 0;
        degenerate_seen   = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        s_valid <= 1'b0;
        waited = 0;
        while (basis_queue.size() != 0 && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (basis_queue.size() != 0) begin
            $display("%0d expected results never arrived", basis_queue.size());
            mismatches++;
        end
        $display("Sent %0d corners; checked %0d triangles, %0d of them degenerate.",
                 corners_sent, triangles_checked, degenerate_seen);
        if (mismatches == 0)
            $display("[triangle_tangent_basis_unit] OK");
        else
            $display("[triangle_tangent_basis_unit] ERROR");
        $finish;
    end

endmodule
